// File: hw/rtl/abp_pkg.sv
// ---------------------------------------------------------------------------
// Angle bisector point package
// Shared constants, payload structs and the arctangent table.
// ---------------------------------------------------------------------------
package abp_pkg;

   localparam int COORD_WIDTH_DEF   = 32;
   localparam int CORDIC_STAGES_DEF = 18;
   localparam int ANGLE_WIDTH       = 32;
   localparam int GUARD_BITS        = 8;
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;
   localparam logic [31:0] INV_GAIN_Q31 = 32'h4DBA_76D4;

   typedef struct packed {
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic signed [31:0] third_x;
      logic signed [31:0] third_y;
      logic signed [31:0] length;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               degenerate;
   } rsp_type;

   function automatic logic [31:0] atan_val(input logic [4:0] s);
      logic [31:0] r;
      begin
         unique case (s)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2F9;
            5'd15: r = 32'h0000517C;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A2F;
            5'd19: r = 32'h00000517;
            5'd20: r = 32'h0000028B;
            5'd21: r = 32'h00000145;
            5'd22: r = 32'h000000A2;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000028;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000002;
            5'd29: r = 32'h00000001;
            default: r = 32'h00000000;
         endcase
         return r;
      end
   endfunction

endpackage

// File: hw/rtl/abp_vec_cell.sv
// ---------------------------------------------------------------------------
// Vectoring cell
// One CORDIC vectoring micro-rotation on both arm vectors, registered.
// ---------------------------------------------------------------------------
module abp_vec_cell #(
   parameter int VW    = 36,
   parameter int SHIFT = 0
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [VW-1:0]  x1_i,
   input  logic signed [VW-1:0]  y1_i,
   input  logic [31:0]           z1_i,
   input  logic signed [VW-1:0]  x3_i,
   input  logic signed [VW-1:0]  y3_i,
   input  logic [31:0]           z3_i,
   output logic signed [VW-1:0]  x1_o,
   output logic signed [VW-1:0]  y1_o,
   output logic [31:0]           z1_o,
   output logic signed [VW-1:0]  x3_o,
   output logic signed [VW-1:0]  y3_o,
   output logic [31:0]           z3_o
);
   import abp_pkg::*;

   localparam logic [31:0] ATAN = atan_val(5'(SHIFT));

   logic signed [VW-1:0] x1_in, y1_in, x3_in, y3_in;
   logic [31:0]          z1_in, z3_in;
   logic signed [VW-1:0] x1_ff, y1_ff, x3_ff, y3_ff;
   logic [31:0]          z1_ff, z3_ff;

   always_comb begin
      if (!y1_i[VW-1]) begin
         x1_in = x1_i + (y1_i >>> SHIFT);
         y1_in = y1_i - (x1_i >>> SHIFT);
         z1_in = z1_i + ATAN;
      end else begin
         x1_in = x1_i - (y1_i >>> SHIFT);
         y1_in = y1_i + (x1_i >>> SHIFT);
         z1_in = z1_i - ATAN;
      end
      if (!y3_i[VW-1]) begin
         x3_in = x3_i + (y3_i >>> SHIFT);
         y3_in = y3_i - (x3_i >>> SHIFT);
         z3_in = z3_i + ATAN;
      end else begin
         x3_in = x3_i - (y3_i >>> SHIFT);
         y3_in = y3_i + (x3_i >>> SHIFT);
         z3_in = z3_i - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= x1_in; y1_ff <= y1_in; z1_ff <= z1_in;
         x3_ff <= x3_in; y3_ff <= y3_in; z3_ff <= z3_in;
      end
   end

   assign x1_o = x1_ff; assign y1_o = y1_ff; assign z1_o = z1_ff;
   assign x3_o = x3_ff; assign y3_o = y3_ff; assign z3_o = z3_ff;
endmodule

// File: hw/rtl/abp_rot_cell.sv
// ---------------------------------------------------------------------------
// Rotation cell
// One CORDIC rotation micro-step on the length vector, registered.
// ---------------------------------------------------------------------------
module abp_rot_cell #(
   parameter int RW    = 44,
   parameter int SHIFT = 0
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [RW-1:0] x_i,
   input  logic signed [RW-1:0] y_i,
   input  logic signed [32:0]   z_i,
   output logic signed [RW-1:0] x_o,
   output logic signed [RW-1:0] y_o,
   output logic signed [32:0]   z_o
);
   import abp_pkg::*;

   localparam logic [31:0] ATAN = atan_val(5'(SHIFT));

   logic signed [RW-1:0] x_in, y_in, x_ff, y_ff;
   logic signed [32:0]   z_in, z_ff;

   always_comb begin
      if (!z_i[32]) begin
         x_in = x_i - (y_i >>> SHIFT);
         y_in = y_i + (x_i >>> SHIFT);
         z_in = z_i - $signed({1'b0, ATAN});
      end else begin
         x_in = x_i + (y_i >>> SHIFT);
         y_in = y_i - (x_i >>> SHIFT);
         z_in = z_i + $signed({1'b0, ATAN});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      end
   end

   assign x_o = x_ff; assign y_o = y_ff; assign z_o = z_ff;
endmodule

// File: hw/rtl/angle_bisector_point.sv
// ---------------------------------------------------------------------------
// Angle bisector point
// Vertex plus a signed length along the bisector of two arms, by CORDIC.
// ---------------------------------------------------------------------------
//   channel  direction  payload
//   req_     in         first, vertex, third point, length (req_type)
//   rsp_     out        point_x, point_y, degenerate (rsp_type)
//
// One transfer is taken per cycle while the output is not stalled. The
// pipeline advances only when its last register is empty or being read, so
// a stall on rsp_ holds every stage.
// Reset clears the valid bits of the pipeline only.
module angle_bisector_point #(
   parameter int CORDIC_STAGES = abp_pkg::CORDIC_STAGES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  abp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output abp_pkg::rsp_type rsp_data
);
   import abp_pkg::*;

   localparam int VW = 36;
   localparam int RW = 44;
   localparam int NS = CORDIC_STAGES;
   localparam int DEPTH = 2 * NS + 5;

   logic en;
   logic [DEPTH-1:0] vld_ff, vld_in;

   assign en        = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[DEPTH-1];

   always_comb begin
      vld_in = {vld_ff[DEPTH-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Side data carried alongside each stage.
   typedef struct packed {
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] len;
      logic               zero_first;
   } side_type;

   side_type side_ff [DEPTH-1];

   // Stage 0: arm vectors and half-turn pre-rotation.
   logic signed [VW-1:0] dx1, dy1, dx3, dy3;
   logic signed [VW-1:0] x1_ff [NS+1], y1_ff [NS+1], x3_ff [NS+1], y3_ff [NS+1];
   logic [31:0]          z1_ff [NS+1], z3_ff [NS+1];
   logic                 zero3;

   always_comb begin
      dx1 = VW'(req_data.first_x) - VW'(req_data.vertex_x);
      dy1 = VW'(req_data.vertex_y) - VW'(req_data.first_y);
      dx3 = VW'(req_data.third_x) - VW'(req_data.vertex_x);
      dy3 = VW'(req_data.vertex_y) - VW'(req_data.third_y);
      zero3 = (dx3 == '0) && (dy3 == '0);
   end

   logic vec_zero3_ff [NS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= '{req_data.vertex_x, req_data.vertex_y, req_data.length,
                         (dx1 == '0) && (dy1 == '0)};
         vec_zero3_ff[0] <= zero3;
         if (dx1[VW-1]) begin
            x1_ff[0] <= -dx1; y1_ff[0] <= -dy1; z1_ff[0] <= HALF_TURN;
         end else begin
            x1_ff[0] <= dx1;  y1_ff[0] <= dy1;  z1_ff[0] <= '0;
         end
         if (dx3[VW-1]) begin
            x3_ff[0] <= -dx3; y3_ff[0] <= -dy3; z3_ff[0] <= HALF_TURN;
         end else begin
            x3_ff[0] <= dx3;  y3_ff[0] <= dy3;  z3_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_vec
      abp_vec_cell #(.VW(VW), .SHIFT(i)) u_cell (
         .clock(clock), .en(en),
         .x1_i(x1_ff[i]), .y1_i(y1_ff[i]), .z1_i(z1_ff[i]),
         .x3_i(x3_ff[i]), .y3_i(y3_ff[i]), .z3_i(z3_ff[i]),
         .x1_o(x1_ff[i+1]), .y1_o(y1_ff[i+1]), .z1_o(z1_ff[i+1]),
         .x3_o(x3_ff[i+1]), .y3_o(y3_ff[i+1]), .z3_o(z3_ff[i+1])
      );
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[i+1]      <= side_ff[i];
            vec_zero3_ff[i+1] <= vec_zero3_ff[i];
         end
      end
   end

   // Bisector direction and first half of the length scaling.
   logic [31:0] a1, a3, d, dir_in, dir_ff;
   logic signed [31:0] hi_in;
   logic [23:0]        lo_in;
   logic signed [31:0] hi_ff;
   logic [23:0]        lo_ff;

   always_comb begin
      a1 = z1_ff[NS];
      a3 = vec_zero3_ff[NS] ? '0 : z3_ff[NS];
      d  = a3 - a1;
      if (d > HALF_TURN) dir_in = a1 - ((32'd0 - d) >> 1);
      else               dir_in = a1 + (d >> 1);
      hi_in = side_ff[NS].len >>> 24;
      lo_in = side_ff[NS].len[23:0];
   end

   // Multiply stage: hi and lo products, registered.
   logic signed [63:0] phi_ff;
   logic signed [56:0] plo_ff;
   logic [31:0]        dir2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dir_ff <= dir_in;
         hi_ff  <= hi_in;
         lo_ff  <= lo_in;
         side_ff[NS+1] <= side_ff[NS];
         phi_ff  <= 64'(hi_ff) * $signed({1'b0, INV_GAIN_Q31});
         plo_ff  <= 57'($signed({1'b0, lo_ff}) * $signed({1'b0, INV_GAIN_Q31}));
         dir2_ff <= dir_ff;
         side_ff[NS+2] <= side_ff[NS+1];
      end
   end

   // Initial rotation vector with quadrant reduction.
   logic signed [RW-1:0] x0;
   logic [1:0]           q;
   logic [31:0]          dred;
   logic signed [RW-1:0] rx_ff [NS+1], ry_ff [NS+1];
   logic signed [32:0]   rz_ff [NS+1];

   always_comb begin
      x0 = RW'(phi_ff <<< 1) + RW'(plo_ff >>> 23);
      q  = dir2_ff[31:30];
      dred = dir2_ff;
      if (q == 2'd1 || q == 2'd2) begin
         x0   = -x0;
         dred = dir2_ff - HALF_TURN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff[0] <= x0;
         ry_ff[0] <= '0;
         rz_ff[0] <= $signed({dred[31], dred});
         side_ff[NS+3] <= side_ff[NS+2];
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_rot
      abp_rot_cell #(.RW(RW), .SHIFT(i)) u_cell (
         .clock(clock), .en(en),
         .x_i(rx_ff[i]), .y_i(ry_ff[i]), .z_i(rz_ff[i]),
         .x_o(rx_ff[i+1]), .y_o(ry_ff[i+1]), .z_o(rz_ff[i+1])
      );
      always_ff @(posedge clock) begin
         if (en) side_ff[NS+4+i] <= side_ff[NS+3+i];
      end
   end

   // Rounding, offset from the vertex (x added, y subtracted), clamp, and the zero first arm case.
   localparam logic signed [RW-1:0] CMAX = RW'((64'sd1 <<< (COORD_WIDTH_DEF - 1)) - 1);
   localparam logic signed [RW-1:0] CMIN = -CMAX - RW'(1);

   side_type             sl;
   logic signed [RW-1:0] ox, oy, px, py, cx, cy;
   logic                 flag;
   rsp_type              out_in, out_ff;

   always_comb begin
      sl = side_ff[2*NS+3];
      ox = (rx_ff[NS] + RW'(128)) >>> GUARD_BITS;
      oy = (ry_ff[NS] + RW'(128)) >>> GUARD_BITS;
      px = RW'(sl.vx) + ox;
      py = RW'(sl.vy) - oy;
      flag = 1'b0;
      cx = px;
      cy = py;
      if (px > CMAX) begin cx = CMAX; flag = 1'b1; end
      else if (px < CMIN) begin cx = CMIN; flag = 1'b1; end
      if (py > CMAX) begin cy = CMAX; flag = 1'b1; end
      else if (py < CMIN) begin cy = CMIN; flag = 1'b1; end
      if (sl.zero_first) begin
         out_in = '{sl.vx, sl.vy, 1'b1};
      end else begin
         out_in = '{32'(cx), 32'(cy), flag};
      end
   end

   always_ff @(posedge clock) begin
      if (en) out_ff <= out_in;
   end

   assign rsp_data = out_ff;
endmodule

// File: verif/testbench.sv
// ---------------------------------------------------------------------------
// Angle bisector point testbench
// Drives point triples and lengths through the block with random bursts and
// gaps, and checks every end point against a bit-exact CORDIC predictor.
// ---------------------------------------------------------------------------
module testbench;
   import abp_pkg::*;

   localparam int STAGES     = CORDIC_STAGES_DEF;
   localparam int LATENCY    = 2 * STAGES + 5;
   localparam int NUM_RANDOM = 1030;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_items[$];
   rsp_type expected_points[$];
   int      error_count = 0;
   int      checked_count = 0;
   int      degenerate_count = 0;
   int      burst_left = 0;
   int      gap_left = 0;
   int      stall_mode = 0;
   bit      stim_done = 1'b0;

   angle_bisector_point u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   function automatic logic [31:0] atan_step(int s);
      logic [31:0] t [0:17];
      t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
            32'h0000517C, 32'h000028BE, 32'h0000145F};
      return t[s];
   endfunction

   // Vectoring CORDIC: direction of (x, y) as a 32-bit binary angle.
   function automatic logic [31:0] arm_angle(longint x, longint y);
      logic [31:0] z;
      longint xs, ys;
      z = '0;
      if (x == 0 && y == 0) return '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = HALF_TURN;
      end
      for (int i = 0; i < STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += atan_step(i);
         end else begin
            x -= ys; y += xs; z -= atan_step(i);
         end
      end
      return z;
   endfunction

   function automatic longint clamp_coord(longint v, ref bit flag);
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         flag = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic rsp_type bisector_point(req_type r);
      rsp_type     p;
      logic [31:0] a1, a3, d, dir;
      longint      len, hi, lo, x, y, z, xs, ys, ox, oy;
      bit          flag;
      flag = 1'b0;
      if (r.first_x == r.vertex_x && r.first_y == r.vertex_y) begin
         p.point_x = r.vertex_x;
         p.point_y = r.vertex_y;
         p.degenerate = 1'b1;
         return p;
      end
      a1 = arm_angle(longint'(r.first_x) - r.vertex_x, longint'(r.vertex_y) - r.first_y);
      a3 = arm_angle(longint'(r.third_x) - r.vertex_x, longint'(r.vertex_y) - r.third_y);
      d = a3 - a1;
      if (d > HALF_TURN) dir = a1 - ((32'd0 - d) >> 1);
      else dir = a1 + (d >> 1);
      // Length times 1/K, split so the product fits in 64 bits.
      len = r.length;
      hi = len >>> 24;
      lo = len - hi * 16777216;
      x = hi * longint'(INV_GAIN_Q31) * 2 + ((lo * longint'(INV_GAIN_Q31)) >>> 23);
      y = 0;
      if (dir[31:30] == 2'd1 || dir[31:30] == 2'd2) begin
         x = -x;
         dir = dir - HALF_TURN;
      end
      z = longint'($signed(dir));
      for (int i = 0; i < STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= longint'(atan_step(i));
         end else begin
            x += ys; y -= xs; z += longint'(atan_step(i));
         end
      end
      ox = (x + 128) >>> GUARD_BITS;
      oy = (y + 128) >>> GUARD_BITS;
      p.point_x = 32'(clamp_coord(longint'(r.vertex_x) + ox, flag));
      p.point_y = 32'(clamp_coord(longint'(r.vertex_y) - oy, flag));
      p.degenerate = flag;
      return p;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h (result %0d)", what, got, want,
               checked_count);
      error_count++;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
         2: return 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
         default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 9)
                                             : 32'h8000_0000 + $urandom_range(0, 9);
      endcase
   endfunction

   function automatic req_type make_item(int x1, int y1, int vx, int vy,
                                         int x3, int y3, int len);
      req_type r;
      r.first_x = x1; r.first_y = y1; r.vertex_x = vx; r.vertex_y = vy;
      r.third_x = x3; r.third_y = y3; r.length = len;
      return r;
   endfunction

   // Driver: bursts of transfers separated by random gaps.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) void'(pending_items.pop_front());
         if (req_valid && !req_ready) begin
            // hold the item until it transfers
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() > ((req_valid && req_ready) ? 0 : 0)) begin
            if (pending_items.size() == 0) req_valid <= 1'b0;
            else begin
               req_valid <= 1'b1;
               req_data  <= pending_items[0];
               if (burst_left > 0) burst_left <= burst_left - 1;
               else begin
                  burst_left <= $urandom_range(0, 30);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end else req_valid <= 1'b0;
      end
   end

   // Every accepted item gets its prediction at the transfer.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) expected_points.push_back(bisector_point(req_data));
   end

   // Receiver stall pattern and result checker.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ~rsp_ready;
         endcase
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               report_mismatch("unexpected result", rsp_data.point_x, 32'd0);
            end else begin
               want = expected_points.pop_front();
               if (rsp_data.point_x !== want.point_x)
                  report_mismatch("point_x", rsp_data.point_x, want.point_x);
               if (rsp_data.point_y !== want.point_y)
                  report_mismatch("point_y", rsp_data.point_y, want.point_y);
               if (rsp_data.degenerate !== want.degenerate)
                  report_mismatch("degenerate", 32'(rsp_data.degenerate),
                                  32'(want.degenerate));
               if (want.degenerate) degenerate_count++;
            end
            checked_count++;
         end
      end
   end

   initial begin
      logic [31:0] vx, vy;
      int          wait_cycles;
      // Directed part.
      pending_items.push_back(make_item(5, 5, 5, 5, 100, 0, 32'h10000));
      pending_items.push_back(make_item(32'h10000, 0, 0, 0, 0, 0, 32'h10000));
      pending_items.push_back(make_item(32'h10000, 0, 0, 0, 32'h20000, 32'h20000, 0));
      pending_items.push_back(make_item(32'h10000, 0, 0, 0, -32'h10000, 0, 32'h50000));
      pending_items.push_back(make_item(-32'h10000, 0, 0, 0, 32'h10000, 0, 32'h50000));
      pending_items.push_back(make_item(0, 32'h10000, 0, 0, 0, -32'h10000, 32'h50000));
      pending_items.push_back(make_item(32'h10000, 0, 0, 0, 0, -32'h10000, 32'h7FFFFFFF));
      pending_items.push_back(make_item(32'h10000, 0, 0, 0, 0, 32'h10000, 32'h80000000));
      pending_items.push_back(make_item(32'h10000, 0, 32'h7FFF0000, 32'h7FFF0000,
                                        32'h7FFF0000, 0, 32'h7FFFFFFF));
      pending_items.push_back(make_item(32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                                        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                        32'h80000000));
      pending_items.push_back(make_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                        32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                                        32'h7FFFFFFF));
      pending_items.push_back(make_item(0, 0, 32'h80000000, 32'h80000000, 0, 0,
                                        32'h80000000));
      pending_items.push_back(make_item(32'h30000, 32'h10000, 0, 0, -32'h10000,
                                        -32'h30000, -32'h40000));
      pending_items.push_back(make_item(32'h10000, 32'h10000, 0, 0, -32'h10000,
                                        -32'h10000, 32'h30000));
      pending_items.push_back(make_item(-32'h10000, -32'h20000, 0, 0, -32'h20000,
                                        32'h10000, 1));
      pending_items.push_back(make_item(0, -32'h10000, 0, 0, -32'h10000, 0, -1));
      // Random part: mostly local geometry, some full-range coordinates.
      for (int n = 0; n < NUM_RANDOM; n++) begin
         req_type r;
         vx = rand_coord();
         vy = rand_coord();
         r.vertex_x = vx;
         r.vertex_y = vy;
         r.first_x = vx + 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
         r.first_y = vy + 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
         r.third_x = vx + 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
         r.third_y = vy + 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
         r.length  = rand_coord();
         case ($urandom_range(0, 19))
            0: begin r.first_x = vx; r.first_y = vy; end
            1: begin r.third_x = vx; r.third_y = vy; end
            2: r.length = 0;
            3: begin
               r.third_x = 2 * vx - r.first_x;
               r.third_y = 2 * vy - r.first_y;
            end
            4: begin
               r.first_x = $urandom(); r.first_y = $urandom();
               r.third_x = $urandom(); r.third_y = $urandom();
            end
            default: ;
         endcase
         pending_items.push_back(r);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (pending_items.size() == 0 && !req_valid);
      wait (expected_points.size() == 0);
      wait_cycles = 0;
      while (wait_cycles < LATENCY + 10) begin
         @(posedge clock);
         wait_cycles++;
      end
      $display("Checked %0d bisector points, %0d of them flagged degenerate,",
               checked_count, degenerate_count);
      $display("with random sender bursts and receiver stalls.");
      if (error_count == 0 && expected_points.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout with %0d results outstanding", expected_points.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
